// File: hdl/sstf_pkg.sv
// shared constants, codes and control types for the sstf disk request scheduler
package sstf_pkg;

  localparam int QueueDepth    = 16;
  localparam int TrackBits     = 10;
  localparam int RequesterBits = 4;
  localparam int LimitW        = 5;
  localparam int OccW          = 5;
  localparam int LimitReset    = 16;

  localparam int IdxW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int CmpW = (CntW > LimitW) ? CntW : LimitW;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SERVICE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_REMOVE = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic remove;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic scan_last;
    logic out_busy;
  } sts_t;

endpackage

// File: hdl/sstf_ctrl.sv
// control state machine: accept, nearest-track scan, removal, result hand-off
module sstf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_operation_i,
  input  sstf_pkg::sts_t sts_i,
  output sstf_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);
  import sstf_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if ((op_e'(in_operation_i) == OP_SERVICE) && !sts_i.empty) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_REMOVE;
        end
      end
      S_REMOVE: begin
        cmd_o.remove = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/sstf_dp.sv
// datapath: pending queue, head position, nearest scan, compaction and result register
module sstf_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_operation_i,
  input  logic [sstf_pkg::RequesterBits-1:0] in_requester_i,
  input  logic [sstf_pkg::TrackBits-1:0]     in_track_i,
  input  logic                               cfg_we_i,
  input  logic [sstf_pkg::LimitW-1:0]        cfg_wdata_i,
  input  logic                               out_stall_i,
  input  sstf_pkg::cmd_t                     cmd_i,
  output sstf_pkg::sts_t                     sts_o,
  output logic                               out_valid_o,
  output sstf_pkg::status_e                  out_status_o,
  output logic [sstf_pkg::RequesterBits-1:0] out_served_requester_o,
  output logic [sstf_pkg::TrackBits-1:0]     out_served_track_o,
  output logic [sstf_pkg::TrackBits-1:0]     out_seek_distance_o,
  output logic [sstf_pkg::OccW-1:0]          out_occupancy_o
);
  import sstf_pkg::*;

  logic [LimitW-1:0]        limit_q;
  logic [RequesterBits-1:0] ent_req_q [QueueDepth];
  logic [TrackBits-1:0]     ent_trk_q [QueueDepth];
  logic [CntW-1:0]          cnt_q;
  logic [TrackBits-1:0]     head_q;
  logic [IdxW-1:0]          idx_q;
  logic [IdxW-1:0]          best_idx_q;
  logic [TrackBits-1:0]     best_dist_q;
  logic [RequesterBits-1:0] best_req_q;
  logic [TrackBits-1:0]     best_trk_q;
  status_e                  res_status_q;
  logic                     out_valid_q;

  logic                     full;
  logic                     enq_we;
  logic [TrackBits-1:0]     scan_trk;
  logic [RequesterBits-1:0] scan_req;
  logic [TrackBits-1:0]     scan_dist;
  logic                     better;

  assign full   = (CmpW'(cnt_q) >= CmpW'(limit_q)) || (cnt_q == CntW'(QueueDepth));
  assign enq_we = cmd_i.accept && (op_e'(in_operation_i) == OP_ENQUEUE) && !full;

  assign scan_trk  = ent_trk_q[idx_q];
  assign scan_req  = ent_req_q[idx_q];
  assign scan_dist = (scan_trk >= head_q) ? (scan_trk - head_q) : (head_q - scan_trk);
  // first entry always taken, later ones only when strictly nearer
  assign better    = (idx_q == '0) || (scan_dist < best_dist_q);

  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.scan_last = ((CntW'(idx_q) + CntW'(1)) == cnt_q);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  // queue row: append at the tail, close the gap above the removed entry
  for (genvar k = 0; k < QueueDepth; k++) begin : g_ent
    if (k < QueueDepth - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (enq_we && (cnt_q[IdxW-1:0] == IdxW'(k))) begin
          ent_req_q[k] <= in_requester_i;
          ent_trk_q[k] <= in_track_i;
        end else if (cmd_i.remove && (IdxW'(k) >= best_idx_q)) begin
          ent_req_q[k] <= ent_req_q[k+1];
          ent_trk_q[k] <= ent_trk_q[k+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (enq_we && (cnt_q[IdxW-1:0] == IdxW'(k))) begin
          ent_req_q[k] <= in_requester_i;
          ent_trk_q[k] <= in_track_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitW'(LimitReset);
      cnt_q       <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (enq_we) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (cmd_i.remove) begin
        cnt_q  <= cnt_q - CntW'(1);
        head_q <= best_trk_q;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q <= '0;
      if (op_e'(in_operation_i) == OP_SERVICE) begin
        res_status_q <= (cnt_q == '0) ? ST_EMPTY : ST_SERVED;
      end else begin
        res_status_q <= full ? ST_FULL : ST_ENQUEUED;
      end
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + IdxW'(1);
      if (better) begin
        best_idx_q  <= idx_q;
        best_dist_q <= scan_dist;
        best_req_q  <= scan_req;
        best_trk_q  <= scan_trk;
      end
    end
    if (cmd_i.finish) begin
      out_status_o    <= res_status_q;
      out_occupancy_o <= OccW'(cnt_q);
      if (res_status_q == ST_SERVED) begin
        out_served_requester_o <= best_req_q;
        out_served_track_o     <= best_trk_q;
        out_seek_distance_o    <= best_dist_q;
      end else begin
        out_served_requester_o <= '0;
        out_served_track_o     <= '0;
        out_seek_distance_o    <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/sstf_disk_request_scheduler.sv
// top level: shortest-seek-time-first disk request scheduler
// sequence: enqueue, full reject and empty service go from accept straight to the finish step;
//   a service scans every pending entry, removes the nearest, then finishes; finish waits on output stall
// throughput: one request at a time; a service takes longer the more requests are pending,
//   as the nearest-track scan reads one queue entry per cycle
// reset: no pending requests, head at track 0, queue limit 16, queue contents undefined
module sstf_disk_request_scheduler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               in_operation_i,
  input  logic [sstf_pkg::RequesterBits-1:0] in_requester_i,
  input  logic [sstf_pkg::TrackBits-1:0]     in_track_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output sstf_pkg::status_e                  out_status_o,
  output logic [sstf_pkg::RequesterBits-1:0] out_served_requester_o,
  output logic [sstf_pkg::TrackBits-1:0]     out_served_track_o,
  output logic [sstf_pkg::TrackBits-1:0]     out_seek_distance_o,
  output logic [sstf_pkg::OccW-1:0]          out_occupancy_o,
  input  logic                               cfg_we_i,
  input  logic [sstf_pkg::LimitW-1:0]        cfg_wdata_i
);
  import sstf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle -> scan (one entry per cycle) -> remove -> finish, or idle -> finish when no scan is needed
  sstf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_operation_i (in_operation_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .in_stall_o     (in_stall_o)
  );

  // queue storage, head register, distance compare and output register
  sstf_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_operation_i         (in_operation_i),
    .in_requester_i         (in_requester_i),
    .in_track_i             (in_track_i),
    .cfg_we_i               (cfg_we_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .out_stall_i            (out_stall_i),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .out_valid_o            (out_valid_o),
    .out_status_o           (out_status_o),
    .out_served_requester_o (out_served_requester_o),
    .out_served_track_o     (out_served_track_o),
    .out_seek_distance_o    (out_seek_distance_o),
    .out_occupancy_o        (out_occupancy_o)
  );

  // a scan step is followed by another scan step or by the removal
  a_scan_then_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan |=> (cmd.scan || cmd.remove))
    else $error("scan left without removal");

  // after a removal the sequencer is busy finishing, never scanning again
  a_remove_then_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.remove |=> (in_stall_o && !cmd.scan && !cmd.remove))
    else $error("removal not followed by finish");

  // service of an empty queue never starts a scan
  a_empty_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && in_operation_i && sts.empty) |=> !cmd.scan)
    else $error("scan started on empty queue");

  // a new result appears only from a finish step
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.finish))
    else $error("result without finish");

endmodule
